// ===== hw/rtl/hrq_pkg.sv =====
// ----------------------------------------------------------------------------
// hrq_pkg
// Shared widths, codes and types of the host request read-priority queue.
// ----------------------------------------------------------------------------
package hrq_pkg;

    // Queue geometry and sector size.
    localparam int QUEUE_DEPTH  = 16;
    localparam int SECTOR_BYTES = 512;
    localparam int IDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 40;
    localparam int SCNT_W   = 16;
    localparam int PAGES_W  = 17;
    localparam int BYTES_W  = 26;
    localparam int STATUS_W = 2;
    localparam int SHIFT_W  = 3;
    localparam int HDR_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // Byte length arithmetic: page count scaled by the largest page shift,
    // then by the sector size.
    localparam int SCALE_W   = PAGES_W + (1 << SHIFT_W) - 1;
    localparam int PROD_W    = SCALE_W + $clog2(SECTOR_BYTES + 1);
    localparam int BYTES_MAX = (1 << BYTES_W) - 1;

    // Decoupling queue between front and back.
    localparam int EVQ_DEPTH = 2;
    localparam int EVQ_IDX_W = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
    localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GRANT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DONE   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GRANT_REJ = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE_REJ  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd2;

    // Configuration reset values.
    localparam logic              MODE_RST   = 1'b1;
    localparam logic [SHIFT_W-1:0] SHIFT_RST  = 3'd3;
    localparam logic [HDR_W-1:0]  HEADER_RST = 12'd64;

    typedef struct packed {
        logic               read_first_mode;
        logic [SHIFT_W-1:0] page_shift;
        logic [HDR_W-1:0]   header_bytes;
    } cfg_t;

    // One queued request.
    typedef struct packed {
        logic [ADDR_W-1:0]  page;
        logic [PAGES_W-1:0] pages;
        logic               rd;
        logic [BYTES_W-1:0] bytes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Classified event kinds handed from front to back.
    typedef enum logic [2:0] {
        EV_PUSH_RD,
        EV_PUSH_WR,
        EV_GRANT,
        EV_DONE,
        EV_BAD
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t kind;
        entry_t   entry;
    } ev_t;

    // One result beat.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                offer_valid;
        entry_t              offer;
        logic                send_request;
    } result_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOK,
        BK_SEND
    } bk_state_t;

endpackage

// ===== hw/rtl/hrq_ram.sv =====
// ----------------------------------------------------------------------------
// hrq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hrq_front.sv =====
// ----------------------------------------------------------------------------
// hrq_front
// Accepts input beats, classifies the command and converts the sector range
// of a submit into a first page, a page count and a transfer byte length.
// ----------------------------------------------------------------------------
module hrq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hrq_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hrq_pkg::CMD_W-1:0]     command,
    input  logic [hrq_pkg::ADDR_W-1:0]    sector_addr,
    input  logic [hrq_pkg::SCNT_W-1:0]    sector_count,
    input  logic                          is_read,
    output logic                          ev_valid,
    input  logic                          ev_ready,
    output hrq_pkg::ev_t                  ev
);

    logic                           s1_valid_reg, s1_valid_next;
    hrq_pkg::ev_kind_t              s1_kind_reg;
    logic [hrq_pkg::ADDR_W-1:0]     s1_page_reg;
    logic [hrq_pkg::PAGES_W-1:0]    s1_first_reg;
    logic [hrq_pkg::PAGES_W-1:0]    s1_last_reg;
    logic                           s1_rd_reg;

    hrq_pkg::ev_kind_t              kind_in;
    logic [hrq_pkg::SCNT_W-1:0]     cnt_eff;
    logic [hrq_pkg::ADDR_W:0]       last_sector;
    logic [hrq_pkg::ADDR_W-1:0]     first_page;
    logic [hrq_pkg::ADDR_W:0]       last_page;
    logic                           load_s1;

    logic [hrq_pkg::PAGES_W-1:0]    pages;
    logic [hrq_pkg::SCALE_W-1:0]    scaled;
    logic [hrq_pkg::PROD_W-1:0]     data_bytes;
    logic [hrq_pkg::PROD_W:0]       total_bytes;
    logic [hrq_pkg::BYTES_W-1:0]    write_bytes;

    // Command decode; a submit goes to the read queue only in read-first mode.
    always_comb
    begin
        unique case (command)
            hrq_pkg::CMD_SUBMIT:
            begin
                kind_in = (cfg.read_first_mode && is_read) ? hrq_pkg::EV_PUSH_RD
                                                           : hrq_pkg::EV_PUSH_WR;
            end
            hrq_pkg::CMD_GRANT: kind_in = hrq_pkg::EV_GRANT;
            hrq_pkg::CMD_DONE:  kind_in = hrq_pkg::EV_DONE;
            default:            kind_in = hrq_pkg::EV_BAD;
        endcase
    end

    // Sector range to first and last page. A zero count counts as one sector.
    assign cnt_eff     = (sector_count == '0) ? hrq_pkg::SCNT_W'(1) : sector_count;
    assign last_sector = {1'b0, sector_addr} + (hrq_pkg::ADDR_W + 1)'(cnt_eff)
                         - (hrq_pkg::ADDR_W + 1)'(1);
    assign first_page  = sector_addr >> cfg.page_shift;
    assign last_page   = last_sector >> cfg.page_shift;

    // The first stage moves on whenever it is empty or hands its beat over.
    assign in_ready      = !s1_valid_reg || ev_ready;
    assign load_s1       = in_valid && in_ready;
    assign s1_valid_next = load_s1 ? 1'b1 : (ev_ready ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_kind_reg  <= kind_in;
            s1_page_reg  <= first_page;
            s1_first_reg <= first_page[hrq_pkg::PAGES_W-1:0];
            s1_last_reg  <= last_page[hrq_pkg::PAGES_W-1:0];
            s1_rd_reg    <= is_read;
        end
    end

    // Page count and byte length; a write carries its page data, saturated.
    assign pages       = s1_last_reg - s1_first_reg + hrq_pkg::PAGES_W'(1);
    assign scaled      = hrq_pkg::SCALE_W'(pages) << cfg.page_shift;
    assign data_bytes  = hrq_pkg::PROD_W'(scaled) * hrq_pkg::PROD_W'(hrq_pkg::SECTOR_BYTES);
    assign total_bytes = (hrq_pkg::PROD_W + 1)'(data_bytes)
                         + (hrq_pkg::PROD_W + 1)'(cfg.header_bytes);
    assign write_bytes = (total_bytes > (hrq_pkg::PROD_W + 1)'(hrq_pkg::BYTES_MAX))
                         ? hrq_pkg::BYTES_W'(hrq_pkg::BYTES_MAX)
                         : total_bytes[hrq_pkg::BYTES_W-1:0];

    always_comb
    begin
        ev.kind        = s1_kind_reg;
        ev.entry.page  = s1_page_reg;
        ev.entry.pages = pages;
        ev.entry.rd    = s1_rd_reg;
        ev.entry.bytes = s1_rd_reg ? hrq_pkg::BYTES_W'(cfg.header_bytes) : write_bytes;
    end

    assign ev_valid = s1_valid_reg;

endmodule

// ===== hw/rtl/hrq_evq.sv =====
// ----------------------------------------------------------------------------
// hrq_evq
// Short event queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module hrq_evq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  hrq_pkg::ev_t  push_ev,
    output logic          pop_valid,
    input  logic          pop_ready,
    output hrq_pkg::ev_t  pop_ev
);

    hrq_pkg::ev_t                   slot_reg [hrq_pkg::EVQ_DEPTH];
    logic [hrq_pkg::EVQ_IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [hrq_pkg::EVQ_IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [hrq_pkg::EVQ_CNT_W-1:0]  count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != hrq_pkg::EVQ_CNT_W'(hrq_pkg::EVQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_ev     = slot_reg[rd_ptr_reg];

    // Pointer and fill count update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == hrq_pkg::EVQ_IDX_W'(hrq_pkg::EVQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == hrq_pkg::EVQ_IDX_W'(hrq_pkg::EVQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_ev;
        end
    end

endmodule

// ===== hw/rtl/hrq_back.sv =====
// ----------------------------------------------------------------------------
// hrq_back
// Carries out classified events on the read and write queues and the channel
// flag, then reads the head entries and forms the offer of the result beat.
// ----------------------------------------------------------------------------
module hrq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  hrq_pkg::cfg_t     cfg,
    input  logic              ev_valid,
    output logic              ev_ready,
    input  hrq_pkg::ev_t      ev,
    output logic              out_valid,
    input  logic              out_ready,
    output hrq_pkg::result_t  result
);

    hrq_pkg::bk_state_t             state_reg, state_next;
    logic [hrq_pkg::CNT_W-1:0]      rd_count_reg, rd_count_next;
    logic [hrq_pkg::CNT_W-1:0]      wr_count_reg, wr_count_next;
    logic [hrq_pkg::IDX_W-1:0]      rd_head_reg, rd_head_next;
    logic [hrq_pkg::IDX_W-1:0]      wr_head_reg, wr_head_next;
    logic                           busy_reg, busy_next;
    logic [hrq_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           ask_reg, ask_next;
    logic                           out_valid_reg, out_valid_next;
    hrq_pkg::result_t               result_reg, result_next;

    logic                           exec;
    logic                           load_out;
    logic                           pick_rd;
    logic                           pick_wr;
    logic                           rd_we;
    logic                           wr_we;
    logic [hrq_pkg::IDX_W-1:0]      rd_waddr;
    logic [hrq_pkg::IDX_W-1:0]      wr_waddr;
    logic [hrq_pkg::ENTRY_W-1:0]    rd_rdata;
    logic [hrq_pkg::ENTRY_W-1:0]    wr_rdata;
    logic                           offer_ok;

    // Slot behind the last entry of a ring: head plus count, wrapped once.
    function automatic logic [hrq_pkg::IDX_W-1:0] tail_index(
        input logic [hrq_pkg::IDX_W-1:0] head,
        input logic [hrq_pkg::CNT_W-1:0] count
    );
        logic [hrq_pkg::IDX_W:0] sum;
        sum = (hrq_pkg::IDX_W + 1)'(head) + (hrq_pkg::IDX_W + 1)'(count);
        if (sum >= (hrq_pkg::IDX_W + 1)'(hrq_pkg::QUEUE_DEPTH))
        begin
            sum = sum - (hrq_pkg::IDX_W + 1)'(hrq_pkg::QUEUE_DEPTH);
        end
        return sum[hrq_pkg::IDX_W-1:0];
    endfunction

    // Head after a pop, wrapped at the queue depth.
    function automatic logic [hrq_pkg::IDX_W-1:0] head_inc(
        input logic [hrq_pkg::IDX_W-1:0] head
    );
        return (head == hrq_pkg::IDX_W'(hrq_pkg::QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    endfunction

    // Queue storage, read at the head of each ring.
    hrq_ram #(
        .WIDTH (hrq_pkg::ENTRY_W),
        .DEPTH (hrq_pkg::QUEUE_DEPTH)
    ) u_rd_ram (
        .clk   (clk),
        .we    (rd_we),
        .waddr (rd_waddr),
        .wdata (ev.entry),
        .raddr (rd_head_reg),
        .rdata (rd_rdata)
    );

    hrq_ram #(
        .WIDTH (hrq_pkg::ENTRY_W),
        .DEPTH (hrq_pkg::QUEUE_DEPTH)
    ) u_wr_ram (
        .clk   (clk),
        .we    (wr_we),
        .waddr (wr_waddr),
        .wdata (ev.entry),
        .raddr (wr_head_reg),
        .rdata (wr_rdata)
    );

    // Sequencer next state: execute, look up the heads, then send.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hrq_pkg::BK_IDLE: if (ev_valid) state_next = hrq_pkg::BK_LOOK;
            hrq_pkg::BK_LOOK: state_next = hrq_pkg::BK_SEND;
            hrq_pkg::BK_SEND: if (!out_valid_reg || out_ready) state_next = hrq_pkg::BK_IDLE;
            default:          state_next = hrq_pkg::BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        ev_ready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            hrq_pkg::BK_IDLE: ev_ready = 1'b1;
            hrq_pkg::BK_LOOK: ;
            hrq_pkg::BK_SEND: load_out = !out_valid_reg || out_ready;
            default:          ;
        endcase
    end

    assign exec = ev_valid && ev_ready;

    // Queue that the offer and a grant use; reads win in read-first mode.
    assign pick_rd = cfg.read_first_mode && (rd_count_reg != '0);
    assign pick_wr = !pick_rd && (wr_count_reg != '0);

    assign rd_waddr = tail_index(rd_head_reg, rd_count_reg);
    assign wr_waddr = tail_index(wr_head_reg, wr_count_reg);

    // Event execution.
    always_comb
    begin
        rd_count_next = rd_count_reg;
        wr_count_next = wr_count_reg;
        rd_head_next  = rd_head_reg;
        wr_head_next  = wr_head_reg;
        busy_next     = busy_reg;
        status_next   = status_reg;
        ask_next      = ask_reg;
        rd_we         = 1'b0;
        wr_we         = 1'b0;
        if (exec)
        begin
            status_next = hrq_pkg::ST_OK;
            ask_next    = 1'b0;
            case (ev.kind)
                hrq_pkg::EV_PUSH_RD:
                begin
                    ask_next = 1'b1;
                    if (rd_count_reg == hrq_pkg::CNT_W'(hrq_pkg::QUEUE_DEPTH))
                    begin
                        status_next = hrq_pkg::ST_FULL;
                    end
                    else
                    begin
                        rd_we         = 1'b1;
                        rd_count_next = rd_count_reg + 1'b1;
                    end
                end
                hrq_pkg::EV_PUSH_WR:
                begin
                    ask_next = 1'b1;
                    if (wr_count_reg == hrq_pkg::CNT_W'(hrq_pkg::QUEUE_DEPTH))
                    begin
                        status_next = hrq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_we         = 1'b1;
                        wr_count_next = wr_count_reg + 1'b1;
                    end
                end
                hrq_pkg::EV_GRANT:
                begin
                    if (busy_reg || (!pick_rd && !pick_wr))
                    begin
                        status_next = hrq_pkg::ST_GRANT_REJ;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        if (pick_rd)
                        begin
                            rd_head_next  = head_inc(rd_head_reg);
                            rd_count_next = rd_count_reg - 1'b1;
                        end
                        else
                        begin
                            wr_head_next  = head_inc(wr_head_reg);
                            wr_count_next = wr_count_reg - 1'b1;
                        end
                    end
                end
                hrq_pkg::EV_DONE:
                begin
                    if (!busy_reg)
                    begin
                        status_next = hrq_pkg::ST_DONE_REJ;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        ask_next  = 1'b1;
                    end
                end
                default:
                begin
                    status_next = hrq_pkg::ST_GRANT_REJ;
                end
            endcase
        end
    end

    // Result beat from the state after the event; offer fields are zero without an offer.
    assign offer_ok = !busy_reg && (pick_rd || pick_wr);

    always_comb
    begin
        result_next              = result_reg;
        out_valid_next           = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next           = 1'b1;
            result_next.status       = status_reg;
            result_next.offer_valid  = offer_ok;
            result_next.send_request = offer_ok && ask_reg;
            if (!offer_ok)
            begin
                result_next.offer = '0;
            end
            else if (pick_rd)
            begin
                result_next.offer = hrq_pkg::entry_t'(rd_rdata);
            end
            else
            begin
                result_next.offer = hrq_pkg::entry_t'(wr_rdata);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrq_pkg::BK_IDLE;
            rd_count_reg  <= '0;
            wr_count_reg  <= '0;
            rd_head_reg   <= '0;
            wr_head_reg   <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_count_reg  <= rd_count_next;
            wr_count_reg  <= wr_count_next;
            rd_head_reg   <= rd_head_next;
            wr_head_reg   <= wr_head_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ask_reg    <= ask_next;
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== hw/rtl/host_request_read_priority_queue.sv =====
// An accepted input beat passes the front stage register, the event queue
// and the back end sequence of execute, head lookup in the registered-read
// queue RAMs, and send; a new event waits until the last result is loaded.
// Reset: queue counts, heads and the channel busy flag clear; configuration
// returns to read-first mode, page shift 3, header 64 bytes. Queue storage
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// host_request_read_priority_queue
// Host request front end: sector to page conversion, read-over-write
// priority queues and a channel grant/complete handshake.
// ----------------------------------------------------------------------------
module host_request_read_priority_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [hrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hrq_pkg::CFG_DAT_W-1:0]      cfg_wdata,
    // Input channel.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hrq_pkg::CMD_W-1:0]          command,
    input  logic [hrq_pkg::ADDR_W-1:0]         sector_addr,
    input  logic [hrq_pkg::SCNT_W-1:0]         sector_count,
    input  logic                               is_read,
    // Result channel.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hrq_pkg::STATUS_W-1:0]       status,
    output logic                               offer_valid,
    output logic [hrq_pkg::ADDR_W-1:0]         offer_page,
    output logic [hrq_pkg::PAGES_W-1:0]        offer_pages,
    output logic                               offer_is_read,
    output logic [hrq_pkg::BYTES_W-1:0]        offer_bytes,
    output logic                               send_request
);

    logic                          mode_reg;
    logic [hrq_pkg::SHIFT_W-1:0]   shift_reg;
    logic [hrq_pkg::HDR_W-1:0]     header_reg;
    hrq_pkg::cfg_t                 cfg;

    logic                          fr_valid;
    logic                          fr_ready;
    hrq_pkg::ev_t                  fr_ev;
    logic                          bk_valid;
    logic                          bk_ready;
    hrq_pkg::ev_t                  bk_ev;
    hrq_pkg::result_t              result;

    // Configuration registers; writes to unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= hrq_pkg::MODE_RST;
            shift_reg  <= hrq_pkg::SHIFT_RST;
            header_reg <= hrq_pkg::HEADER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hrq_pkg::CFG_MODE:   mode_reg   <= cfg_wdata[0];
                hrq_pkg::CFG_SHIFT:  shift_reg  <= cfg_wdata[hrq_pkg::SHIFT_W-1:0];
                hrq_pkg::CFG_HEADER: header_reg <= cfg_wdata[hrq_pkg::HDR_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg.read_first_mode = mode_reg;
    assign cfg.page_shift      = shift_reg;
    assign cfg.header_bytes    = header_reg;

    hrq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .sector_addr  (sector_addr),
        .sector_count (sector_count),
        .is_read      (is_read),
        .ev_valid     (fr_valid),
        .ev_ready     (fr_ready),
        .ev           (fr_ev)
    );

    hrq_evq u_evq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_ev    (fr_ev),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_ev     (bk_ev)
    );

    hrq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ev_valid  (bk_valid),
        .ev_ready  (bk_ready),
        .ev        (bk_ev),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // Result beat fields.
    assign status        = result.status;
    assign offer_valid   = result.offer_valid;
    assign offer_page    = result.offer.page;
    assign offer_pages   = result.offer.pages;
    assign offer_is_read = result.offer.rd;
    assign offer_bytes   = result.offer.bytes;
    assign send_request  = result.send_request;

endmodule
